[rtl/core/absolute_humidity_fan_hysteresis_defines.svh]
// assertion macros shared by the rtl
`ifndef ABSOLUTE_HUMIDITY_FAN_HYSTERESIS_DEFINES_SVH
`define ABSOLUTE_HUMIDITY_FAN_HYSTERESIS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk_i, off during reset
`define AHFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk_i, off during reset
`define AHFH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AHFH_ASSERT_IMP(lbl, ante, cons, msg)
`define AHFH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/ahfh_pkg.sv]
`default_nettype none
package ahfh_pkg;

  // shared multiplier operand widths
  localparam int unsigned MUL_AW = 40;
  localparam int unsigned MUL_BW = 26;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // shared divider widths
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 32;

  // ln(2) in q30, seed of the power table
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // arithmetic constants
  localparam logic [MUL_AW-1:0] EXP_K_Q32  = 40'd107006793954;
  localparam logic [MUL_AW-1:0] MAGNUS_NUM = 40'd610780000;
  localparam logic [MUL_AW-1:0] GAS_DEN    = 40'd46151;
  localparam logic [16:0]       DEN_Y_OFS  = 17'd23730;
  localparam logic [16:0]       KELVIN_OFS = 17'd27315;
  localparam logic [39:0]       Y_BIAS     = 40'h40_0000_0000;
  localparam logic [6:0]        SHIFT_BASE = 7'd105;
  localparam logic [20:0]       ABS_MAX    = 21'd2000000;

  // register map (word index)
  localparam logic [1:0] REG_ON_MARGIN  = 2'd0;
  localparam logic [1:0] REG_OFF_MARGIN = 2'd1;
  localparam logic [1:0] REG_INTERVAL   = 2'd2;

  // sequencer states
  typedef enum logic [16:0] {
    ST_IDLE = 17'b00000000000000001,
    ST_SEL  = 17'b00000000000000010,
    ST_MNUM = 17'b00000000000000100,
    ST_DYLD = 17'b00000000000001000,
    ST_DYW  = 17'b00000000000010000,
    ST_YFIX = 17'b00000000000100000,
    ST_POS  = 17'b00000000001000000,
    ST_RDLO = 17'b00000000010000000,
    ST_RDHI = 17'b00000000100000000,
    ST_INTP = 17'b00000001000000000,
    ST_P22  = 17'b00000010000000000,
    ST_GDEN = 17'b00000100000000000,
    ST_DBLD = 17'b00001000000000000,
    ST_DBW  = 17'b00010000000000000,
    ST_PROD = 17'b00100000000000000,
    ST_SHFT = 17'b01000000000000000,
    ST_DONE = 17'b10000000000000000
  } state_e;

endpackage
`default_nettype wire

[rtl/core/ahfh_mul.sv]
`default_nettype none
module ahfh_mul import ahfh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [MUL_AW-1:0] a_i,
  input  wire logic [MUL_BW-1:0] b_i,
  output logic      [MUL_PW-1:0] p_o
);

  logic [MUL_PW-1:0] p_q;

  // registered unsigned product
  always_ff @(posedge clk_i) begin
    p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/core/ahfh_div.sv]
`default_nettype none
module ahfh_div import ahfh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] dividend_i,
  input  wire logic [DIV_DW-1:0] divisor_i,
  output logic      [DIV_NW-1:0] quot_o,
  output logic      [DIV_DW-1:0] rem_o,
  output logic                   busy_o
);

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [CW-1:0]     cnt_q;
  logic [DIV_NW-1:0] quot_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] div_q;
  logic [DIV_DW:0]   trial;
  logic              qbit;
  logic [DIV_DW:0]   diff;

  // one restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_q, quot_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign qbit  = (trial >= {1'b0, div_q});

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DIV_NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[DIV_NW-2:0], qbit};
      rem_q  <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign busy_o = (cnt_q != '0);

endmodule
`default_nettype wire

[rtl/core/ahfh_pow_rom.sv]
`default_nettype none
module ahfh_pow_rom import ahfh_pkg::*; #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW      = $clog2(ENTRIES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] addr_i,
  output logic      [31:0]   data_o
);

  typedef logic [31:0] tab_t [0:ENTRIES];

  // 2^(k/ENTRIES) in q30 by a series of exp(k ln2 / ENTRIES) up to the 24th-power term
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    for (int k = 0; k <= int'(ENTRIES); k++) begin
      z    = (64'(k) * LN2_Q30) / ENTRIES;
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        sum  = sum + term;
      end
      tab[k] = sum[31:0];
    end
    return tab;
  endfunction

  localparam tab_t POW_TAB = build_tab();

  logic [31:0] data_q;

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= POW_TAB[addr_i];
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

[rtl/core/absolute_humidity_fan_hysteresis.sv]
`default_nettype none
// one sample in flight at a time; each valid reading takes two 64-step radix-2
// divisions in the shared divider
// the next sample can be taken once the result sits in the output register
// reset: asynchronous active low; fan off, sample count 10, margins 3000/2000, interval 10
`include "absolute_humidity_fan_hysteresis_defines.svh"
module absolute_humidity_fan_hysteresis import ahfh_pkg::*; #(
  parameter int unsigned POW_TABLE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [14:0] inside_temp_i,
  input  wire logic [13:0] inside_rh_i,
  input  wire logic        inside_ok_i,
  input  wire logic [14:0] outside_temp_i,
  input  wire logic [13:0] outside_rh_i,
  input  wire logic        outside_ok_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [20:0] inside_abs_o,
  output logic             inside_abs_ok_o,
  output logic      [20:0] outside_abs_o,
  output logic             outside_abs_ok_o,
  output logic             fan_drive_o,
  output logic             decided_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(POW_TABLE_ENTRIES + 1);

  state_e st_q, st_d;

  logic [16:0] on_q, off_q;
  logic [7:0]  intv_q, count_q;
  logic        fan_q;
  logic        sel_q;
  logic        out_valid_q;

  logic [14:0] temp_q [2];
  logic [13:0] rh_q   [2];
  logic [1:0]  ok_q;
  logic [20:0] abs_q  [2];

  logic [6:0]    ip_q;
  logic [31:0]   fr_q;
  logic [AW-1:0] idx_q;
  logic [31:0]   rem_q;
  logic [31:0]   lo_q;
  logic [23:0]   p22_q;
  logic [31:0]   gden_q;

  logic [20:0] o_in_abs_q, o_out_abs_q;
  logic        o_in_ok_q, o_out_ok_q, o_fan_q, o_dec_q;

  logic              mul_load;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_DW-1:0] div_rem;
  logic              div_busy;

  logic          rom_en;
  logic [AW-1:0] rom_addr;
  logic [31:0]   rom_data;

  logic [14:0] cur_t;
  logic [13:0] cur_rh;
  logic        cur_ok;
  logic        tneg;
  logic [14:0] tmag;
  logic [16:0] dy_sum, tk_sum;
  logic [38:0] qmag;
  logic [39:0] ybias;
  logic [31:0] p30;
  logic [32:0] p22_w;
  logic [6:0]  shamt;
  logic [64:0] rnd;
  logic [20:0] abs_w;
  logic        cfg_wr;
  logic        done_load;
  logic        decide;
  logic [21:0] on_lim, off_lim;
  logic        fan_next;

  // current reading
  assign cur_t  = temp_q[sel_q];
  assign cur_rh = rh_q[sel_q];
  assign cur_ok = ok_q[sel_q];
  assign tneg   = cur_t[14];
  assign tmag   = tneg ? 15'(-cur_t) : cur_t;
  assign dy_sum = DEN_Y_OFS + {{2{cur_t[14]}}, cur_t};
  assign tk_sum = KELVIN_OFS + {{2{cur_t[14]}}, cur_t};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_MNUM: begin
        mul_a = EXP_K_Q32;
        mul_b = MUL_BW'(tmag);
      end
      ST_POS: begin
        mul_a = MUL_AW'(fr_q);
        mul_b = MUL_BW'(POW_TABLE_ENTRIES);
      end
      ST_INTP: begin
        mul_a = MUL_AW'(rem_q);
        mul_b = MUL_BW'(rom_data - lo_q);
      end
      ST_P22: begin
        mul_a = GAS_DEN;
        mul_b = MUL_BW'(tk_sum[15:0]);
      end
      ST_GDEN: begin
        mul_a = MAGNUS_NUM;
        mul_b = MUL_BW'(cur_rh);
      end
      ST_PROD: begin
        mul_a = MUL_AW'(div_quot[33:0]);
        mul_b = MUL_BW'(p22_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_load = 1'b1;

  ahfh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_load ? mul_a : '0),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // divider load: exponent quotient, then gas-law quotient
  assign div_start = (st_q == ST_DYLD) || (st_q == ST_DBLD);
  always_comb begin
    if (st_q == ST_DBLD) begin
      div_num = {1'b0, mul_p[43:0], 19'b0};
      div_den = gden_q;
    end else begin
      div_num = DIV_NW'(mul_p[51:0]);
      div_den = DIV_DW'(dy_sum[15:0]);
    end
  end

  ahfh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .busy_o     (div_busy)
  );

  // power table reads: low entry then high entry
  assign rom_en   = (st_q == ST_RDLO) || (st_q == ST_RDHI);
  assign rom_addr = (st_q == ST_RDHI) ? idx_q + AW'(1) : mul_p[32 +: AW];

  ahfh_pow_rom #(
    .ENTRIES (POW_TABLE_ENTRIES),
    .AW      (AW)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (rom_en),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  // floor of the exponent and its bias to a positive value
  assign qmag  = 39'(div_quot[37:0]) + 39'(tneg && (div_rem != '0));
  assign ybias = tneg ? Y_BIAS - 40'(qmag) : Y_BIAS + 40'(qmag);

  // interpolated power, rounded to q22
  assign p30   = lo_q + mul_p[63:32];
  assign p22_w = (33'(p30) + 33'd128) >> 8;

  // final rounding shift and saturation
  assign shamt = SHIFT_BASE - ip_q;
  assign rnd   = ({1'b0, mul_p[63:0]} + (65'd1 << (shamt - 7'd1))) >> shamt;
  always_comb begin
    if (shamt >= 7'd64) begin
      abs_w = '0;
    end else if (rnd > 65'(ABS_MAX)) begin
      abs_w = ABS_MAX;
    end else begin
      abs_w = rnd[20:0];
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_SEL;
      ST_SEL: begin
        if (cur_ok) begin
          st_d = ST_MNUM;
        end else if (sel_q) begin
          st_d = ST_DONE;
        end
      end
      ST_MNUM: st_d = ST_DYLD;
      ST_DYLD: st_d = ST_DYW;
      ST_DYW:  if (!div_busy) st_d = ST_YFIX;
      ST_YFIX: st_d = ST_POS;
      ST_POS:  st_d = ST_RDLO;
      ST_RDLO: st_d = ST_RDHI;
      ST_RDHI: st_d = ST_INTP;
      ST_INTP: st_d = ST_P22;
      ST_P22:  st_d = ST_GDEN;
      ST_GDEN: st_d = ST_DBLD;
      ST_DBLD: st_d = ST_DBW;
      ST_DBW:  if (!div_busy) st_d = ST_PROD;
      ST_PROD: st_d = ST_SHFT;
      ST_SHFT: st_d = sel_q ? ST_DONE : ST_SEL;
      ST_DONE: if (!out_valid_q || out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // decision on the finished sample
  assign done_load = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign decide    = (count_q >= intv_q);
  assign on_lim    = 22'(abs_q[1]) + 22'(on_q);
  assign off_lim   = 22'(abs_q[1]) + 22'(off_q);
  always_comb begin
    fan_next = fan_q;
    if (decide && ok_q[0] && ok_q[1]) begin
      if (22'(abs_q[0]) > on_lim) begin
        fan_next = 1'b1;
      end else if (22'(abs_q[0]) <= off_lim) begin
        fan_next = 1'b0;
      end
    end
  end

  // configuration writes
  assign cfg_wr = psel && penable && pwrite && pready;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      sel_q       <= 1'b0;
      fan_q       <= 1'b0;
      count_q     <= 8'd10;
      out_valid_q <= 1'b0;
      on_q        <= 17'd3000;
      off_q       <= 17'd2000;
      intv_q      <= 8'd10;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE) begin
        sel_q <= 1'b0;
      end else if ((st_q == ST_SHFT) || ((st_q == ST_SEL) && !cur_ok)) begin
        sel_q <= 1'b1;
      end
      if (done_load) begin
        fan_q       <= fan_next;
        count_q     <= decide ? 8'd0 : count_q + 8'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ON_MARGIN:  on_q   <= pwdata[16:0];
          REG_OFF_MARGIN: off_q  <= pwdata[16:0];
          REG_INTERVAL:   intv_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if ((st_q == ST_IDLE) && in_valid_i) begin
      temp_q[0] <= inside_temp_i;
      temp_q[1] <= outside_temp_i;
      rh_q[0]   <= inside_rh_i;
      rh_q[1]   <= outside_rh_i;
      ok_q      <= {outside_ok_i, inside_ok_i};
    end
    if ((st_q == ST_SEL) && !cur_ok) begin
      abs_q[sel_q] <= '0;
    end
    if (st_q == ST_SHFT) begin
      abs_q[sel_q] <= abs_w;
    end
    if (st_q == ST_YFIX) begin
      ip_q <= ybias[38:32];
      fr_q <= ybias[31:0];
    end
    if (st_q == ST_RDLO) begin
      idx_q <= mul_p[32 +: AW];
      rem_q <= mul_p[31:0];
    end
    if (st_q == ST_RDHI) begin
      lo_q <= rom_data;
    end
    if (st_q == ST_P22) begin
      p22_q <= p22_w[23:0];
    end
    if (st_q == ST_GDEN) begin
      gden_q <= mul_p[31:0];
    end
    if (done_load) begin
      o_in_abs_q  <= abs_q[0];
      o_out_abs_q <= abs_q[1];
      o_in_ok_q   <= ok_q[0];
      o_out_ok_q  <= ok_q[1];
      o_fan_q     <= fan_next;
      o_dec_q     <= decide;
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_ON_MARGIN:  prdata = 32'(on_q);
      REG_OFF_MARGIN: prdata = 32'(off_q);
      REG_INTERVAL:   prdata = 32'(intv_q);
      default:        prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign in_ready_o       = (st_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign inside_abs_o     = o_in_abs_q;
  assign inside_abs_ok_o  = o_in_ok_q;
  assign outside_abs_o    = o_out_abs_q;
  assign outside_abs_ok_o = o_out_ok_q;
  assign fan_drive_o      = o_fan_q;
  assign decided_o        = o_dec_q;

  // checks
  `AHFH_ASSERT_IMP(a_idle_div, in_ready_o, !div_busy, "divider busy while idle")
  `AHFH_ASSERT_NXT(a_div_runs, st_q == ST_DYLD, div_busy, "divider did not start")
  `AHFH_ASSERT_IMP(a_fan_on_done, !$stable(fan_q), $past(done_load), "fan changed off a result")
  `AHFH_ASSERT_NXT(a_done_valid, done_load, out_valid_o, "result not presented")

endmodule
`default_nettype wire
